>>> rtl/core/efla_pkg.sv
package efla_pkg;

  localparam int MaxExtents = 64;
  localparam int IdxW       = $clog2(MaxExtents);
  localparam int CntW       = IdxW + 1;
  localparam int BlockW     = 32;
  localparam int SpBlocks   = 512;
  localparam int SpW        = $clog2(SpBlocks);

  typedef logic [BlockW-1:0] blk_t;

  localparam logic [1:0] ReqInit  = 2'd0;
  localparam logic [1:0] ReqFree  = 2'd1;
  localparam logic [1:0] ReqAlloc = 2'd2;

  localparam logic [1:0] CfgRangeFirst = 2'd0;
  localparam logic [1:0] CfgRangeLast  = 2'd1;
  localparam logic [1:0] CfgLogReserve = 2'd2;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_COUNT,
    ST_RANGE,
    ST_OVERLAP,
    ST_NO_SPACE,
    ST_FULL
  } status_e;

  typedef struct packed {
    logic [1:0] req_type;
    blk_t       block_number;
    blk_t       block_count;
    logic       is_data;
    logic       carve_high;
    logic       contiguous_only;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    blk_t       start_block;
    blk_t       granted_count;
    blk_t       free_total;
  } rsp_t;

  typedef struct packed {
    blk_t lo;
    blk_t hi;
  } ext_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_INSERT,
    OP_REMOVE
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] idx;
    logic            wr_lo;
    logic            wr_hi;
    ext_t            ext;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY_A,
    S_APPLY_B,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    MODE_FREE,
    MODE_SUPER,
    MODE_FIRST
  } mode_e;

endpackage

>>> rtl/core/efla_cell.sv
module efla_cell import efla_pkg::*; (
  input  logic            clk_i,
  input  logic [IdxW-1:0] pos_i,
  input  cmd_t            cmd_i,
  input  ext_t            left_i,
  input  ext_t            right_i,
  output ext_t            ext_o
);

  ext_t ext_q, ext_d;

  always_comb begin
    ext_d = ext_q;
    unique case (cmd_i.op)
      OP_NONE: begin
      end
      OP_WRITE: begin
        if (cmd_i.idx == pos_i) begin
          if (cmd_i.wr_lo) ext_d.lo = cmd_i.ext.lo;
          if (cmd_i.wr_hi) ext_d.hi = cmd_i.ext.hi;
        end
      end
      OP_INSERT: begin
        if (pos_i == cmd_i.idx) begin
          ext_d = cmd_i.ext;
        end else if (pos_i > cmd_i.idx) begin
          ext_d = left_i;
        end
      end
      OP_REMOVE: begin
        if (pos_i >= cmd_i.idx) ext_d = right_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ext_q <= ext_d;
  end

  assign ext_o = ext_q;

endmodule

>>> rtl/core/efla_chain.sv
module efla_chain import efla_pkg::*; (
  input  logic            clk_i,
  input  cmd_t            cmd_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output ext_t            rd_ext_o
);

  ext_t cell_ext [MaxExtents];

  for (genvar j = 0; j < MaxExtents; j++) begin : g_cell
    ext_t left_w, right_w;
    if (j == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_ext[j-1];
    end
    if (j == MaxExtents - 1) begin : g_last
      assign right_w = cell_ext[j];
    end else begin : g_mid_r
      assign right_w = cell_ext[j+1];
    end
    efla_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (IdxW'(j)),
      .cmd_i   (cmd_i),
      .left_i  (left_w),
      .right_i (right_w),
      .ext_o   (cell_ext[j])
    );
  end

  assign rd_ext_o = cell_ext[rd_idx_i];

endmodule

>>> rtl/core/extent_free_list_allocator.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_data_i  (req_t)
// out       output     out_valid_o / out_ready_i out_data_o (rsp_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
// One request is processed at a time. A scan reads one extent per cycle through a
// one-stage read pipeline, and an allocation that misses the superpage pass scans
// the table again for a first fit.
// Table updates shift the chain of cells by one place per cycle, at most two per request.
// Reset clears the extent count and free total; the extent cells hold no reset value.
// A new request is taken while the previous result waits on a stalled output.
module extent_free_list_allocator import efla_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  req_t       in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rsp_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  blk_t       cfg_data_i
);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  req_t   req_q, req_d;
  blk_t   hi_q, hi_d;
  blk_t   rf_q, rl_q, res_q;
  logic [CntW-1:0] count_q, count_d;
  blk_t   free_q, free_d;
  logic [CntW-1:0] rd_k_q, rd_k_d;
  logic   pipe_v_q, pipe_v_d;
  logic   in_rng_q, in_rng_d;
  ext_t   cur_q, cur_d;
  logic [IdxW-1:0] cur_idx_q, cur_idx_d;
  logic [BlockW:0] size_q, size_d;
  blk_t   prev_hi_q, prev_hi_d;
  logic [IdxW-1:0] prev_idx_q, prev_idx_d;
  logic   have_prev_q, have_prev_d;
  cmd_t   cmd_a_q, cmd_a_d, cmd_b_q, cmd_b_d;
  logic   b_v_q, b_v_d;
  logic [2:0] st_q, st_d;
  blk_t   start_q, start_d, grant_q, grant_d;
  rsp_t   out_q, out_d;
  logic   out_v_q, out_v_d;

  logic   in_fire, can_load, go_resp, go_scan, go_apply;
  cmd_t   chain_cmd;
  ext_t   rd_ext;
  logic [IdxW-1:0] rd_idx;
  logic [BlockW:0] cnt33, lmar33, avail, rmar;
  logic [SpW:0]    lmar;
  logic   sp_fit, lm, rm;
  blk_t   take, fr_idx_lo;
  logic [IdxW-1:0] fr_idx;

  function automatic cmd_t mk_cmd(op_e op, logic [IdxW-1:0] idx, logic wl, logic wh,
                                  blk_t lo, blk_t hi);
    cmd_t c;
    c.op     = op;
    c.idx    = idx;
    c.wr_lo  = wl;
    c.wr_hi  = wh;
    c.ext.lo = lo;
    c.ext.hi = hi;
    return c;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign can_load    = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign chain_cmd = (state_q == S_APPLY_A) ? cmd_a_q :
                     (state_q == S_APPLY_B) ? cmd_b_q :
                     mk_cmd(OP_NONE, '0, 1'b0, 1'b0, '0, '0);

  assign rd_idx = (mode_q != MODE_FREE && req_q.carve_high) ?
                  (count_q[IdxW-1:0] - IdxW'(1) - rd_k_q[IdxW-1:0]) : rd_k_q[IdxW-1:0];

  efla_chain u_chain (
    .clk_i    (clk_i),
    .cmd_i    (chain_cmd),
    .rd_idx_i (rd_idx),
    .rd_ext_o (rd_ext)
  );

  // Superpage, first-fit and free-merge arithmetic on the registered extent.
  always_comb begin
    cnt33  = {1'b0, req_q.block_count};
    lmar   = (cur_q.lo[SpW-1:0] != '0) ?
             ((SpW+1)'(SpBlocks) - {1'b0, cur_q.lo[SpW-1:0]}) : '0;
    lmar33 = (BlockW+1)'(lmar);
    avail  = size_q - lmar33;
    sp_fit = (size_q > lmar33) && (cnt33 <= avail);
    rmar   = avail - cnt33;
    fr_idx = in_rng_q ? cur_idx_q : count_q[IdxW-1:0];
    fr_idx_lo = cur_q.lo;
    lm     = have_prev_q && (({1'b0, prev_hi_q} + 33'd1) == {1'b0, req_q.block_number});
    rm     = in_rng_q && (({1'b0, hi_q} + 33'd1) == {1'b0, fr_idx_lo});
    take   = req_q.block_count;
    if (cnt33 >= size_q) take = size_q[BlockW-1:0] - res_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (go_apply) state_d = S_APPLY_A;
          else if (go_scan) state_d = S_SCAN;
          else state_d = S_RESP;
        end
      end
      S_SCAN: begin
        if (go_apply) state_d = S_APPLY_A;
        else if (go_resp) state_d = S_RESP;
      end
      S_APPLY_A: state_d = b_v_q ? S_APPLY_B : S_RESP;
      S_APPLY_B: state_d = S_RESP;
      S_RESP: begin
        if (can_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    mode_d = mode_q; req_d = req_q; hi_d = hi_q; count_d = count_q; free_d = free_q;
    rd_k_d = rd_k_q; pipe_v_d = pipe_v_q; in_rng_d = in_rng_q; cur_d = cur_q;
    cur_idx_d = cur_idx_q; size_d = size_q; prev_hi_d = prev_hi_q;
    prev_idx_d = prev_idx_q; have_prev_d = have_prev_q;
    cmd_a_d = cmd_a_q; cmd_b_d = cmd_b_q; b_v_d = b_v_q;
    st_d = st_q; start_d = start_q; grant_d = grant_q;
    out_d = out_q; out_v_d = out_v_q;
    go_resp = 1'b0; go_scan = 1'b0; go_apply = 1'b0;

    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          hi_d = in_data_i.block_number + in_data_i.block_count - 32'd1;
          st_d = 3'(ST_OK); start_d = '0; grant_d = '0;
          b_v_d = 1'b0; rd_k_d = '0; pipe_v_d = 1'b0; have_prev_d = 1'b0;
          unique case (in_data_i.req_type)
            ReqInit: begin
              free_d = '0;
              if (rf_q > rl_q) begin
                count_d = '0; st_d = 3'(ST_RANGE);
              end else begin
                count_d = CntW'(1);
                free_d = rl_q - rf_q + 32'd1;
                cmd_a_d = mk_cmd(OP_WRITE, '0, 1'b1, 1'b1, rf_q, rl_q);
                go_apply = 1'b1;
              end
            end
            ReqFree: begin
              mode_d = MODE_FREE;
              if (in_data_i.block_count == '0) begin
                st_d = 3'(ST_BAD_COUNT);
              end else if (in_data_i.block_number < rf_q || in_data_i.block_number > rl_q ||
                           (in_data_i.block_count - 32'd1) > (rl_q - in_data_i.block_number))
              begin
                st_d = 3'(ST_RANGE);
              end else begin
                go_scan = 1'b1;
              end
            end
            ReqAlloc: begin
              mode_d = (in_data_i.is_data && in_data_i.block_count[SpW-1:0] == '0) ?
                       MODE_SUPER : MODE_FIRST;
              if (in_data_i.block_count == '0) begin
                st_d = 3'(ST_BAD_COUNT);
              end else if (count_q == '0 || free_q == '0) begin
                st_d = 3'(ST_NO_SPACE);
              end else begin
                go_scan = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        pipe_v_d  = 1'b1;
        in_rng_d  = rd_k_q < count_q;
        cur_d     = rd_ext;
        cur_idx_d = rd_idx;
        size_d    = {1'b0, rd_ext.hi} - {1'b0, rd_ext.lo} + 33'd1;
        rd_k_d    = rd_k_q + CntW'(1);
        if (pipe_v_q) begin
          unique case (mode_q)
            MODE_FREE: begin
              if (in_rng_q && cur_q.hi < req_q.block_number) begin
                prev_hi_d = cur_q.hi; prev_idx_d = cur_idx_q; have_prev_d = 1'b1;
              end else if (in_rng_q && cur_q.lo <= hi_q) begin
                st_d = 3'(ST_OVERLAP); go_resp = 1'b1;
              end else if (lm && rm) begin
                cmd_a_d = mk_cmd(OP_WRITE, prev_idx_q, 1'b0, 1'b1, '0, cur_q.hi);
                cmd_b_d = mk_cmd(OP_REMOVE, fr_idx, 1'b0, 1'b0, '0, '0);
                b_v_d = 1'b1; go_apply = 1'b1;
                free_d = free_q + req_q.block_count;
              end else if (lm) begin
                cmd_a_d = mk_cmd(OP_WRITE, prev_idx_q, 1'b0, 1'b1, '0, hi_q);
                go_apply = 1'b1; free_d = free_q + req_q.block_count;
              end else if (rm) begin
                cmd_a_d = mk_cmd(OP_WRITE, fr_idx, 1'b1, 1'b0, req_q.block_number, '0);
                go_apply = 1'b1; free_d = free_q + req_q.block_count;
              end else if (count_q >= CntW'(MaxExtents)) begin
                st_d = 3'(ST_FULL); go_resp = 1'b1;
              end else begin
                cmd_a_d = mk_cmd(OP_INSERT, fr_idx, 1'b1, 1'b1, req_q.block_number, hi_q);
                go_apply = 1'b1; free_d = free_q + req_q.block_count;
              end
            end
            MODE_SUPER: begin
              if (!in_rng_q) begin
                mode_d = MODE_FIRST; rd_k_d = '0; pipe_v_d = 1'b0;
              end else if (sp_fit && !(lmar != '0 && rmar != '0 &&
                                       count_q >= CntW'(MaxExtents))) begin
                start_d = cur_q.lo + BlockW'(lmar);
                grant_d = req_q.block_count;
                free_d = free_q - req_q.block_count;
                go_apply = 1'b1;
                if (lmar != '0) begin
                  cmd_a_d = mk_cmd(OP_WRITE, cur_idx_q, 1'b0, 1'b1, '0,
                                   cur_q.lo + BlockW'(lmar) - 32'd1);
                  if (rmar != '0) begin
                    cmd_b_d = mk_cmd(OP_INSERT, cur_idx_q + IdxW'(1), 1'b1, 1'b1,
                                     cur_q.lo + BlockW'(lmar) + req_q.block_count, cur_q.hi);
                    b_v_d = 1'b1;
                  end
                end else if (rmar != '0) begin
                  cmd_a_d = mk_cmd(OP_WRITE, cur_idx_q, 1'b1, 1'b0,
                                   cur_q.lo + req_q.block_count, '0);
                end else begin
                  cmd_a_d = mk_cmd(OP_REMOVE, cur_idx_q, 1'b0, 1'b0, '0, '0);
                end
              end
            end
            MODE_FIRST: begin
              if (!in_rng_q) begin
                st_d = 3'(ST_NO_SPACE); go_resp = 1'b1;
              end else if (cnt33 >= size_q && req_q.contiguous_only && cnt33 > size_q) begin
                pipe_v_d = 1'b1;
              end else if (cnt33 >= size_q && req_q.is_data &&
                           size_q == {1'b0, free_q} && size_q <= {1'b0, res_q}) begin
                st_d = 3'(ST_NO_SPACE); go_resp = 1'b1;
              end else if (cnt33 >= size_q && !(req_q.is_data && size_q == {1'b0, free_q}))
              begin
                start_d = cur_q.lo;
                grant_d = size_q[BlockW-1:0];
                free_d = free_q - size_q[BlockW-1:0];
                cmd_a_d = mk_cmd(OP_REMOVE, cur_idx_q, 1'b0, 1'b0, '0, '0);
                go_apply = 1'b1;
              end else begin
                grant_d = take;
                free_d = free_q - take;
                go_apply = 1'b1;
                if (req_q.carve_high) begin
                  start_d = cur_q.hi + 32'd1 - take;
                  cmd_a_d = mk_cmd(OP_WRITE, cur_idx_q, 1'b0, 1'b1, '0, cur_q.hi - take);
                end else begin
                  start_d = cur_q.lo;
                  cmd_a_d = mk_cmd(OP_WRITE, cur_idx_q, 1'b1, 1'b0, cur_q.lo + take, '0);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_APPLY_A, S_APPLY_B: begin
        if (chain_cmd.op == OP_INSERT) count_d = count_q + CntW'(1);
        else if (chain_cmd.op == OP_REMOVE) count_d = count_q - CntW'(1);
      end
      S_RESP: begin
        if (can_load) begin
          out_v_d = 1'b1;
          out_d.status = st_q;
          out_d.start_block = start_q;
          out_d.granted_count = grant_q;
          out_d.free_total = free_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_FREE;
      count_q <= '0;
      free_q  <= '0;
      out_v_q <= 1'b0;
      pipe_v_q <= 1'b0;
      b_v_q   <= 1'b0;
      rf_q    <= '0;
      rl_q    <= 32'd4095;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      count_q <= count_d;
      free_q  <= free_d;
      out_v_q <= out_v_d;
      pipe_v_q <= pipe_v_d;
      b_v_q   <= b_v_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgRangeFirst: rf_q <= cfg_data_i;
          CfgRangeLast:  rl_q <= cfg_data_i;
          CfgLogReserve: res_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; hi_q <= hi_d; rd_k_q <= rd_k_d; in_rng_q <= in_rng_d;
    cur_q <= cur_d; cur_idx_q <= cur_idx_d; size_q <= size_d;
    prev_hi_q <= prev_hi_d; prev_idx_q <= prev_idx_d; have_prev_q <= have_prev_d;
    cmd_a_q <= cmd_a_d; cmd_b_q <= cmd_b_d;
    st_q <= st_d; start_q <= start_d; grant_q <= grant_d; out_q <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxExtents)) else $error("extent count beyond table size");

  a_apply_b_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY_B |-> $past(state_q) == S_APPLY_A)
    else $error("second table update without a first");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_cmd.op == OP_INSERT |-> count_q < CntW'(MaxExtents))
    else $error("insert into a full table");

  a_remove_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_cmd.op == OP_REMOVE |-> count_q != '0)
    else $error("remove from an empty table");

endmodule
